### design/vssm_pkg.sv
// ----------------------------------------------------------------------------
// vssm_pkg
// shared types and constants for the voice slot saturating mixer
// ----------------------------------------------------------------------------
`default_nettype none

package vssm_pkg;

   localparam int Slots      = 32;
   localparam int SlotW      = 5;
   localparam int CursorW    = 6;
   localparam int Sounds     = 4;
   localparam int SoundW     = 2;
   localparam int StoreDepth = 65536;
   localparam int AddrW      = 16;
   localparam int PosW       = 17;
   localparam int CsrIdxW    = 3;
   localparam int CsrDataW   = 17;

   localparam logic signed [15:0] PcmMax = 16'sh7fff;
   localparam logic signed [15:0] PcmMin = 16'sh8000;

   typedef enum logic [1:0] {
      ACT_TICK    = 2'd0,
      ACT_TRIGGER = 2'd1,
      ACT_WRITE   = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_SAMPLE   = 2'd0,
      ST_QUEUED   = 2'd1,
      ST_REJECTED = 2'd2,
      ST_WRITTEN  = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]         action;
      logic [1:0]         sound_id;
      logic [15:0]        store_address;
      logic signed [15:0] store_sample;
   } req_type;

   typedef struct packed {
      logic signed [15:0] mixed_sample;
      logic [1:0]         status;
      logic [4:0]         slot_index;
      logic [5:0]         busy_count;
   } rsp_type;

   function automatic logic signed [15:0] clamp16(input logic signed [17:0] v);
      if (v > 18'(PcmMax)) return PcmMax;
      if (v < 18'(PcmMin)) return PcmMin;
      return v[15:0];
   endfunction

endpackage

`default_nettype wire

### design/voice_slot_saturating_mixer.sv
// ----------------------------------------------------------------------------
// voice_slot_saturating_mixer
// sample playback mixer with 32 voice slots and four stored sounds
// ----------------------------------------------------------------------------
// channel  ports                         direction
// req      req_push/req_full/req_item    in, queue write side
// rsp      rsp_empty/rsp_pop/rsp_item    out, queue read side
// csr      csr_valid/csr_ready/idx/data  in, register writes
//
// a tick walks every slot once after intake, then drains the last read and outputs
// a trigger runs a linear search over the slots, starting at the cursor
// a write item goes from intake straight to output; the back end holds one item at a time
// reset is synchronous; slot state clears at once, the store stays unknown
// a two-beat intake queue keeps req accepting while a result waits
// ----------------------------------------------------------------------------
`default_nettype none

module voice_slot_saturating_mixer (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_push,
   output logic                           req_full,
   input  vssm_pkg::req_type              req_item,
   output logic                           rsp_empty,
   input  wire                            rsp_pop,
   output vssm_pkg::rsp_type              rsp_item,
   input  wire                            csr_valid,
   output logic                           csr_ready,
   input  wire [vssm_pkg::CsrIdxW-1:0]    csr_index,
   input  wire [vssm_pkg::CsrDataW-1:0]   csr_data
);
   import vssm_pkg::*;

   logic    q_valid, q_take;
   req_type q_item;

   // register writes are always taken
   assign csr_ready = 1'b1;

   vssm_front u_front (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .full    (req_full),
      .req_in  (req_item),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_take  (q_take)
   );

   vssm_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_take   (q_take),
      .csr_we   (csr_valid),
      .csr_idx  (csr_index),
      .csr_data (csr_data),
      .empty    (rsp_empty),
      .pop      (rsp_pop),
      .rsp      (rsp_item)
   );

endmodule

`default_nettype wire

### design/vssm_front.sv
// ----------------------------------------------------------------------------
// vssm_front
// input beat intake: drops unused actions, holds a two-entry queue
// ----------------------------------------------------------------------------
`default_nettype none

module vssm_front (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   output logic                full,
   input  vssm_pkg::req_type   req_in,
   output logic                q_valid,
   output vssm_pkg::req_type   q_item,
   input  wire                 q_take
);
   import vssm_pkg::*;

   req_type    mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       wr;

   // action 3 is swallowed here, never queued
   assign full    = (cnt_ff == 2'd2);
   assign wr      = push && !full && (req_in.action != ACT_NONE);
   assign q_valid = (cnt_ff != 2'd0);
   assign q_item  = mem_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff ^ wr;
      rp_in  = rp_ff ^ (q_take && q_valid);
      cnt_in = cnt_ff + 2'(wr) - 2'(q_take && q_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (wr) mem_ff[wp_ff] <= req_in;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'd2) else $error("front queue count overflow");
   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      (q_take && !q_valid) |=> $stable(rp_ff)) else $error("pointer moved on empty take");
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      full |-> q_valid) else $error("full while empty");

endmodule

`default_nettype wire

### design/vssm_back.sv
// ----------------------------------------------------------------------------
// vssm_back
// slot engine: trigger search, tick walk, sample store and result register
// ----------------------------------------------------------------------------
`default_nettype none

module vssm_back (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       q_valid,
   input  vssm_pkg::req_type         q_item,
   output logic                      q_take,
   input  wire                       csr_we,
   input  wire [vssm_pkg::CsrIdxW-1:0]  csr_idx,
   input  wire [vssm_pkg::CsrDataW-1:0] csr_data,
   output logic                      empty,
   input  wire                       pop,
   output vssm_pkg::rsp_type         rsp
);
   import vssm_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SRCH  = 5'b00010,
      S_TICK  = 5'b00100,
      S_ACC   = 5'b01000,
      S_OUT   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [15:0] base_ff [Sounds];
   logic [16:0] len_ff  [Sounds];

   logic              busy_ff [Slots];
   logic [SoundW-1:0] snd_ff  [Slots];
   logic [PosW-1:0]   pos_ff  [Slots];
   logic [CursorW-1:0] cursor_ff;

   logic [15:0] store_mem [StoreDepth];
   logic [15:0] rd_ff;

   req_type      cur_ff;
   logic [SlotW-1:0] idx_ff;
   logic [SlotW:0]   k_ff;
   logic signed [15:0] sum_ff;
   logic         acc_pend_ff;
   rsp_type      rsp_ff;
   logic         full_ff;

   logic [SoundW-1:0] vs;
   logic             play;
   logic [15:0]      raddr;

   assign empty  = !full_ff;
   assign rsp    = rsp_ff;
   assign q_take = (state_ff == S_IDLE) && q_valid && !full_ff;

   assign vs    = snd_ff[idx_ff];
   assign play  = busy_ff[idx_ff] && ({15'd0, pos_ff[idx_ff]} < {15'd0, len_ff[vs]});
   assign raddr = base_ff[vs] + pos_ff[idx_ff][15:0];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (q_take) begin
            unique case (action_type'(q_item.action))
               ACT_TICK:    state_in = S_TICK;
               ACT_TRIGGER: state_in = S_SRCH;
               default:     state_in = S_OUT;
            endcase
         end
         S_SRCH: if (!busy_ff[idx_ff] || k_ff == (SlotW+1)'(Slots - 1)) state_in = S_OUT;
         S_TICK: if (idx_ff == SlotW'(Slots - 1)) state_in = S_ACC;
         S_ACC:  state_in = S_OUT;
         S_OUT:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cursor_ff <= '0;
         full_ff   <= 1'b0;
         for (int i = 0; i < Sounds; i++) begin
            base_ff[i] <= '0;
            len_ff[i]  <= 17'd1;
         end
         for (int i = 0; i < Slots; i++) begin
            busy_ff[i] <= 1'b0;
            snd_ff[i]  <= '0;
            pos_ff[i]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            if (csr_idx[0]) len_ff[csr_idx[2:1]]  <= csr_data;
            else            base_ff[csr_idx[2:1]] <= csr_data[15:0];
         end
         if (full_ff && pop) full_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (q_take) begin
               cur_ff      <= q_item;
               k_ff        <= '0;
               sum_ff      <= '0;
               acc_pend_ff <= 1'b0;
               // a tick walks from slot 0, a trigger from the cursor (slot 0 once past the last slot)
               if (q_item.action == ACT_TICK) idx_ff <= '0;
               else idx_ff <= (cursor_ff < CursorW'(Slots)) ? cursor_ff[SlotW-1:0] : '0;
               rsp_ff      <= '0;
            end
            S_SRCH: begin
               if (!busy_ff[idx_ff]) begin
                  busy_ff[idx_ff]   <= 1'b1;
                  snd_ff[idx_ff]    <= cur_ff.sound_id;
                  pos_ff[idx_ff]    <= '0;
                  cursor_ff         <= CursorW'(idx_ff) + 1'b1;
                  rsp_ff.status     <= ST_QUEUED;
                  rsp_ff.slot_index <= idx_ff;
               end else if (k_ff == (SlotW+1)'(Slots - 1)) begin
                  rsp_ff.status     <= ST_REJECTED;
                  rsp_ff.busy_count <= 6'(Slots);
               end
               k_ff   <= k_ff + 1'b1;
               idx_ff <= (idx_ff == SlotW'(Slots - 1)) ? '0 : idx_ff + 1'b1;
            end
            S_TICK: begin
               // accumulate previous slot's read while addressing this one
               if (acc_pend_ff)
                  sum_ff <= clamp16(18'(sum_ff) + 18'($signed(rd_ff)));
               acc_pend_ff <= 1'b0;
               if (busy_ff[idx_ff]) begin
                  if (play) begin
                     pos_ff[idx_ff] <= pos_ff[idx_ff] + 1'b1;
                     acc_pend_ff    <= 1'b1;
                  end else begin
                     busy_ff[idx_ff] <= 1'b0;
                     pos_ff[idx_ff]  <= '0;
                  end
               end
               if (idx_ff != SlotW'(Slots - 1)) idx_ff <= idx_ff + 1'b1;
            end
            S_ACC: begin
               if (acc_pend_ff)
                  sum_ff <= clamp16(18'(sum_ff) + 18'($signed(rd_ff)));
            end
            S_OUT: begin
               full_ff <= 1'b1;
               if (cur_ff.action == ACT_TICK) begin
                  rsp_ff.mixed_sample <= sum_ff;
                  rsp_ff.status       <= ST_SAMPLE;
               end else if (cur_ff.action == ACT_WRITE) begin
                  rsp_ff.status <= ST_WRITTEN;
               end
            end
            default: ;
         endcase
      end
   end

   // sample store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (state_ff == S_OUT && cur_ff.action == ACT_WRITE)
         store_mem[cur_ff.store_address] <= cur_ff.store_sample;
      rd_ff <= store_mem[raddr];
   end

   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   a_no_take_full: assert property (@(posedge clock) disable iff (reset)
      q_take |-> !full_ff) else $error("item taken while result waits");
   a_cursor: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= CursorW'(Slots)) else $error("cursor out of range");
   a_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) |=> full_ff) else $error("result not registered");

endmodule

`default_nettype wire

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the voice slot saturating mixer: a queue-fed
// driver, a clocked monitor and an in-bench mixer model that predicts every
// result beat from the accepted request beats and the sound registers
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import vssm_pkg::*;

   localparam int CycleLimit = 1500000;
   localparam int DrainCycles = 40;      // one tick walk plus margin
   localparam int LowSpan = 640;         // low store window kept written
   localparam int HighStart = 65472;     // high store window kept written
   localparam int PhaseItems = 250;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   req_type req_item = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   rsp_type rsp_item;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CsrIdxW-1:0] csr_index = '0;
   logic [CsrDataW-1:0] csr_data = '0;

   voice_slot_saturating_mixer dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_item(req_item),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_item(rsp_item),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #10 clock = ~clock;

   // mixer model state
   logic               voice_busy [Slots];
   logic [SoundW-1:0]  voice_sound [Slots];
   logic [PosW-1:0]    voice_pos [Slots];
   logic [CursorW-1:0] next_free_ptr;
   logic [AddrW-1:0]   sound_base [Sounds];
   logic [PosW-1:0]    sound_len [Sounds];
   logic signed [15:0] pcm_store [StoreDepth];

   req_type pending_beats [$];
   rsp_type mix_results [$];

   int send_idle_pct = 0;
   int pop_stall_pct = 0;
   logic hold_pop = 1'b0;
   bit long_hold_go = 0;
   int mismatches = 0;
   int cycle_count = 0;

   initial begin
      for (int s = 0; s < Slots; s++) begin
         voice_busy[s] = 1'b0;
         voice_sound[s] = '0;
         voice_pos[s] = '0;
      end
      next_free_ptr = '0;
      for (int k = 0; k < Sounds; k++) begin
         sound_base[k] = '0;
         sound_len[k] = 17'd1;
      end
   end

   task automatic report_mismatch(string field, int got, int want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", field, got, want,
               cycle_count);
      mismatches++;
   endtask

   // walk every slot once, clamping the running sum after each add
   function automatic logic signed [15:0] mix_one_tick();
      int acc;
      int snd;
      logic [AddrW-1:0] addr;
      acc = 0;
      for (int s = 0; s < Slots; s++) begin
         if (!voice_busy[s]) continue;
         snd = voice_sound[s];
         if (voice_pos[s] >= sound_len[snd]) begin
            voice_busy[s] = 1'b0;
            voice_pos[s] = '0;
            continue;
         end
         addr = sound_base[snd] + voice_pos[s][AddrW-1:0];
         acc = acc + int'(pcm_store[addr]);
         if (acc > 32767) acc = 32767;
         if (acc < -32768) acc = -32768;
         voice_pos[s] = voice_pos[s] + 1'b1;
      end
      return 16'(acc);
   endfunction

   task automatic predict_mix(req_type beat);
      rsp_type r;
      int start;
      int s;
      bit found;
      r = '0;
      found = 0;
      case (action_type'(beat.action))
         ACT_TICK: begin
            r.mixed_sample = mix_one_tick();
            r.status = ST_SAMPLE;
         end
         ACT_TRIGGER: begin
            start = (next_free_ptr < Slots) ? int'(next_free_ptr) : 0;
            for (int k = 0; k < Slots && !found; k++) begin
               s = (start + k) % Slots;
               if (!voice_busy[s]) begin
                  voice_busy[s] = 1'b1;
                  voice_sound[s] = beat.sound_id;
                  voice_pos[s] = '0;
                  next_free_ptr = CursorW'(s + 1);
                  r.slot_index = SlotW'(s);
                  found = 1;
               end
            end
            if (found) r.status = ST_QUEUED;
            else begin
               r.status = ST_REJECTED;
               r.busy_count = (Slots > 63) ? 6'd63 : 6'(Slots);
            end
         end
         ACT_WRITE: begin
            pcm_store[beat.store_address] = beat.store_sample;
            r.status = ST_WRITTEN;
         end
         default: return;   // unused action, no result beat
      endcase
      mix_results.push_back(r);
   endtask

   // driver: an offered beat stays up until it is taken
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) predict_mix(req_item);
         if (!req_push || !req_full) begin
            if (pending_beats.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_item <= pending_beats.pop_front();
               req_push <= 1'b1;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each popped beat with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (mix_results.size() == 0) begin
               report_mismatch("unexpected beat status", rsp_item.status, -1);
            end else begin
               rsp_type want;
               want = mix_results.pop_front();
               if (rsp_item.mixed_sample !== want.mixed_sample)
                  report_mismatch("mixed_sample", rsp_item.mixed_sample, want.mixed_sample);
               if (rsp_item.status !== want.status)
                  report_mismatch("status", rsp_item.status, want.status);
               if (rsp_item.slot_index !== want.slot_index)
                  report_mismatch("slot_index", rsp_item.slot_index, want.slot_index);
               if (rsp_item.busy_count !== want.busy_count)
                  report_mismatch("busy_count", rsp_item.busy_count, want.busy_count);
            end
         end
         rsp_pop <= !hold_pop && ($urandom_range(0, 99) >= pop_stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   // long receiver hold-off so the intake queue fills and req_full rises
   initial begin
      wait (long_hold_go);
      @(posedge clock);
      hold_pop <= 1'b1;
      repeat (600) @(posedge clock);
      hold_pop <= 1'b0;
   end

   task automatic csr_write(logic [CsrIdxW-1:0] idx, logic [CsrDataW-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      // register taken at this edge
      if (idx[0]) sound_len[idx >> 1] = value;
      else sound_base[idx >> 1] = value[AddrW-1:0];
      csr_valid <= 1'b0;
   endtask

   task automatic set_sounds(int b0, int l0, int b1, int l1, int b2, int l2, int b3, int l3);
      csr_write(3'd0, 17'(b0));
      csr_write(3'd1, 17'(l0));
      csr_write(3'd2, 17'(b1));
      csr_write(3'd3, 17'(l1));
      csr_write(3'd4, 17'(b2));
      csr_write(3'd5, 17'(l2));
      csr_write(3'd6, 17'(b3));
      csr_write(3'd7, 17'(l3));
   endtask

   // sender waits until every beat is out and every prediction met
   task automatic wait_quiet();
      while (pending_beats.size() > 0 || req_push || mix_results.size() > 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   function automatic req_type make_beat(action_type act);
      req_type b;
      b.action = act;
      b.sound_id = SoundW'($urandom_range(0, 3));
      b.store_address = AddrW'($urandom);
      b.store_sample = 16'($urandom);
      return b;
   endfunction

   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(0, 5))
         0: return PcmMax;
         1: return PcmMin;
         2: return 16'sd24000;
         default: return 16'($urandom);
      endcase
   endfunction

   // writes only land in the kept windows when they must stay readable
   function automatic req_type make_write(bit anywhere);
      req_type b;
      b = make_beat(ACT_WRITE);
      b.store_sample = pick_sample();
      if (!anywhere) begin
         if ($urandom_range(0, 3) == 0) b.store_address = AddrW'($urandom_range(HighStart, 65535));
         else b.store_address = AddrW'($urandom_range(0, LowSpan - 1));
      end
      return b;
   endfunction

   task automatic queue_random(int count);
      int n;
      int burst;
      int pick;
      n = 0;
      while (n < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            // trigger burst, long enough to fill every slot at times
            burst = $urandom_range(5, 36);
            repeat (burst) pending_beats.push_back(make_beat(ACT_TRIGGER));
            n += burst;
         end else if (pick < 45) begin
            pending_beats.push_back(make_beat(ACT_TICK));
            n++;
         end else if (pick < 70) begin
            pending_beats.push_back(make_beat(ACT_TRIGGER));
            n++;
         end else if (pick < 95) begin
            pending_beats.push_back(make_write($urandom_range(0, 1)));
            n++;
         end else begin
            pending_beats.push_back(make_beat(ACT_NONE));
         end
      end
   endtask

   initial begin
      req_type b;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // extreme registers: zero length, full length, base at store top
      set_sounds(0, 1, 100, 5, 65535, 0, HighStart, 65536);

      // fill both store windows so no voice ever reads an unwritten entry
      for (int a = 0; a < LowSpan; a++) begin
         b = make_beat(ACT_WRITE);
         b.store_address = AddrW'(a);
         b.store_sample = pick_sample();
         pending_beats.push_back(b);
      end
      for (int a = HighStart; a < 65536; a++) begin
         b = make_beat(ACT_WRITE);
         b.store_address = AddrW'(a);
         b.store_sample = pick_sample();
         pending_beats.push_back(b);
      end

      // directed: empty tick, every sound, extreme writes, unused action
      pending_beats.push_back(make_beat(ACT_TICK));
      for (int k = 0; k < Sounds; k++) begin
         b = make_beat(ACT_TRIGGER);
         b.sound_id = SoundW'(k);
         pending_beats.push_back(b);
      end
      repeat (3) pending_beats.push_back(make_beat(ACT_TICK));
      b = make_beat(ACT_WRITE);
      b.store_address = 16'hffff;
      b.store_sample = PcmMin;
      pending_beats.push_back(b);
      b.store_address = 16'h0000;
      b.store_sample = PcmMax;
      pending_beats.push_back(b);
      pending_beats.push_back(make_beat(ACT_NONE));
      repeat (4) pending_beats.push_back(make_beat(ACT_TICK));
      pending_beats.push_back(make_beat(ACT_NONE));
      wait_quiet();

      // phase 0: no idling, with one long receiver hold-off
      queue_random(PhaseItems);
      long_hold_go = 1;
      wait_quiet();

      // phase 1: sender mostly idle
      set_sounds($urandom_range(0, 400), $urandom_range(1, 40),
                 $urandom_range(0, 400), $urandom_range(1, 40),
                 $urandom_range(0, 400), $urandom_range(1, 40),
                 $urandom_range(0, 400), $urandom_range(1, 40));
      send_idle_pct = 87;
      queue_random(PhaseItems);
      wait_quiet();

      // phase 2: receiver mostly stalled, long sounds keep every slot busy
      set_sounds(200, 65536, 65535, 3, 0, 1, 400, 64);
      send_idle_pct = 0;
      pop_stall_pct = 87;
      queue_random(PhaseItems);
      wait_quiet();

      // phase 3: light idling on both sides, short and zero lengths
      set_sounds($urandom_range(0, 400), $urandom_range(0, 20),
                 $urandom_range(0, 400), $urandom_range(0, 20),
                 $urandom_range(0, 400), 0,
                 $urandom_range(0, 400), $urandom_range(0, 20));
      send_idle_pct = 8;
      pop_stall_pct = 8;
      queue_random(PhaseItems);
      wait_quiet();

      if (mix_results.size() != 0)
         report_mismatch("predictions left over", 0, mix_results.size());
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire
